[rtl/drop_tail_link_queue_timer_defines.svh]
// Assertion macros for the drop-tail link queue timer checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef DROP_TAIL_LINK_QUEUE_TIMER_DEFINES_SVH
`define DROP_TAIL_LINK_QUEUE_TIMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTLQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTLQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dtlq_pkg.sv]
// Shared types, constants and helpers for the drop-tail link queue timer.
// No dependencies.
package dtlq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_W       = 36;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam logic [47:0] T48_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_PUSH      = 3'd0;
  localparam logic [2:0] KIND_POP       = 3'd1;
  localparam logic [2:0] KIND_INFLIGHT  = 3'd2;
  localparam logic [2:0] KIND_DELIVERED = 3'd3;
  localparam logic [2:0] KIND_DELAY     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CFG_LIMIT = 2'd0;
  localparam logic [1:0] CFG_PROP  = 2'd1;
  localparam logic [1:0] CFG_RATE  = 2'd2;

  typedef enum logic [1:0] {RD_HEAD, RD_TAIL, RD_WALK} rd_sel_t;
  typedef enum logic [1:0] {EV_NONE, EV_FULL, EV_FRAC} eval_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PUSH_DIV, S_POP, S_DELAY, S_WALK_RD, S_WALK_EVAL,
    S_MUL_HI, S_DIV_START, S_FRAC_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    drop;
    logic    flag_empty;
    logic    push_div_start;
    logic    push_commit;
    logic    pop_commit;
    logic    walk_add_full;
    logic    mul_lo;
    logic    mul_hi;
    logic    frac_div_start;
    logic    walk_add_q;
    logic    walk_next;
    logic    walk_finish;
    logic    delay_empty;
    logic    delay_eval;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       push_ok;
    logic       empty;
    logic       walk_more;
    eval_t      eval;
    logic       div_done;
  } dp_stat_t;

  // Ring position k entries past head.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] k);
    logic [IDX_W+1:0] sum;
    sum = (IDX_W+2)'(head) + (IDX_W+2)'(k);
    if (sum >= (IDX_W+2)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+2)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[rtl/dtlq_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on dtlq_pkg.
module dtlq_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dtlq_pkg::DIV_W-1:0] divisor,
  input  logic [dtlq_pkg::DIV_W-1:0] rem_init,
  input  logic [dtlq_pkg::DIV_W-1:0] dividend,
  output logic                      done,
  output logic [dtlq_pkg::DIV_W-1:0] quotient
);
  import dtlq_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W:0]       rem_sh;
  logic                 ge;
  logic [DIV_W:0]       rem_sub;

  assign rem_sh  = {rem, dvd[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem      <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      dvd      <= {dvd[DIV_W-2:0], 1'b0};
      quotient <= {quotient[DIV_W-2:0], ge};
    end
  end

endmodule

[rtl/dtlq_dp.sv]
// Datapath: configuration, slot memory, counters, multiplier and result registers.
// Depends on dtlq_pkg and dtlq_div.
module dtlq_dp (
  input  logic               clk,
  input  logic               rst,
  input  dtlq_pkg::dp_cmd_t  cmd,
  output dtlq_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [2:0]         kind,
  input  logic [15:0]        packet_bytes,
  input  logic [47:0]        now_ticks,
  output logic [1:0]         status,
  output logic [47:0]        byte_amount_q16,
  output logic signed [47:0] remaining_delay,
  output logic [31:0]        dropped_total
);
  import dtlq_pkg::*;

  logic [23:0] cfg_limit;
  logic [31:0] cfg_prop;
  logic [31:0] cfg_rate;

  logic [2:0]  op_kind;
  logic [15:0] op_size;
  logic [47:0] op_now;

  logic [15:0] slot_size  [QUEUE_DEPTH];
  logic [47:0] slot_start [QUEUE_DEPTH];
  logic [47:0] slot_end   [QUEUE_DEPTH];

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [23:0]      buffered;
  logic [31:0]      delivered;
  logic [31:0]      drop_count;
  logic [CNT_W-1:0] walk_k;

  logic [15:0] rd_size;
  logic [47:0] rd_start;
  logic [47:0] rd_end;

  logic [48:0] acc;
  logic [1:0]  res_status;
  logic [47:0] res_delay;

  logic [49:0] prod_lo;
  logic [17:0] num_hi;
  logic [35:0] frac_den;
  logic [67:0] prod;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      full;
  logic [47:0]      num_w;
  logic [47:0]      den_w;
  eval_t            eval;

  logic             div_start;
  logic [DIV_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_dvd;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  logic [48:0] start_sum;
  logic [47:0] start_base;
  logic [47:0] start_v;
  logic [48:0] end_sum;
  logic [47:0] end_v;
  logic [32:0] deliv_sum;
  logic [48:0] delay_diff;
  logic [47:0] delay_sat;

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_TAIL: rd_addr = slot_at(head, count - 1'b1);
      RD_WALK: rd_addr = slot_at(head, walk_k);
      default: rd_addr = head;
    endcase
  end

  assign wr_addr = slot_at(head, count);
  assign full    = {rd_size, 16'h0000};
  assign num_w   = (op_kind == KIND_INFLIGHT) ? rd_end - op_now : op_now - rd_start;
  assign den_w   = rd_end - rd_start;

  always_comb begin
    if (op_kind == KIND_INFLIGHT) begin
      if (op_now < rd_start) eval = EV_FULL;
      else if (op_now < rd_end) eval = EV_FRAC;
      else eval = EV_NONE;
    end else begin
      if (op_now > rd_end) eval = EV_FULL;
      else if (op_now > rd_start) eval = EV_FRAC;
      else eval = EV_NONE;
    end
  end

  assign stat.kind      = op_kind;
  assign stat.push_ok   = ((25'(buffered) + 25'(op_size)) < 25'(cfg_limit)) &&
                          (count < CNT_W'(QUEUE_DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.walk_more = (walk_k < count);
  assign stat.eval      = eval;
  assign stat.div_done  = div_done;

  // Push: size*8 in Q16 over the rate; fraction: product over span.
  assign div_start   = cmd.push_div_start | cmd.frac_div_start;
  assign div_divisor = cmd.push_div_start ?
                       ((cfg_rate == '0) ? DIV_W'(1) : DIV_W'(cfg_rate)) : frac_den;
  assign div_rem     = cmd.push_div_start ? '0 : DIV_W'(prod[67:36]);
  assign div_dvd     = cmd.push_div_start ? DIV_W'({op_size, 19'h0}) : prod[35:0];

  dtlq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .done     (div_done),
    .quotient (div_q)
  );

  assign start_sum  = 49'(op_now) + 49'(cfg_prop);
  assign start_base = start_sum[48] ? T48_MAX : start_sum[47:0];
  assign start_v    = ((count != '0) && (rd_end > start_base)) ? rd_end : start_base;
  assign end_sum    = 49'(start_v) + 49'(div_q);
  assign end_v      = end_sum[48] ? T48_MAX : end_sum[47:0];
  assign deliv_sum  = 33'(delivered) + 33'(rd_size);
  assign delay_diff = {1'b0, rd_end} - {1'b0, op_now};

  always_comb begin
    if (!delay_diff[48] && delay_diff[47]) delay_sat = 48'h7FFF_FFFF_FFFF;
    else if (delay_diff[48] && !delay_diff[47]) delay_sat = 48'h8000_0000_0000;
    else delay_sat = delay_diff[47:0];
  end

  // Configuration and queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_limit  <= 24'd65536;
      cfg_prop   <= '0;
      cfg_rate   <= 32'd65536;
      head       <= '0;
      count      <= '0;
      buffered   <= '0;
      delivered  <= '0;
      drop_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIMIT: cfg_limit <= cfg_data[23:0];
          CFG_PROP:  cfg_prop  <= cfg_data;
          CFG_RATE:  cfg_rate  <= cfg_data;
          default:   ;
        endcase
      end
      if (cmd.drop && drop_count != U32_MAX) begin
        drop_count <= drop_count + 1'b1;
      end
      if (cmd.push_commit) begin
        count    <= count + 1'b1;
        buffered <= buffered + 24'(op_size);
      end
      if (cmd.pop_commit) begin
        delivered <= deliv_sum[32] ? U32_MAX : deliv_sum[31:0];
        buffered  <= (buffered >= 24'(rd_size)) ? buffered - 24'(rd_size) : '0;
        head      <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count     <= count - 1'b1;
      end
      if (cmd.walk_finish && op_kind == KIND_DELIVERED) begin
        delivered <= '0;
      end
    end
  end

  // Slot memory, registered read.
  always_ff @(posedge clk) begin
    if (cmd.push_commit) begin
      slot_size[wr_addr]  <= op_size;
      slot_start[wr_addr] <= start_v;
      slot_end[wr_addr]   <= end_v;
    end
    if (cmd.rd_en) begin
      rd_size  <= slot_size[rd_addr];
      rd_start <= slot_start[rd_addr];
      rd_end   <= slot_end[rd_addr];
    end
  end

  // Item operands, accumulator and results.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_kind    <= kind;
      op_size    <= packet_bytes;
      op_now     <= now_ticks;
      acc        <= '0;
      res_status <= ST_OK;
      res_delay  <= '0;
      walk_k     <= '0;
    end
    if (cmd.drop) res_status <= ST_DROP;
    if (cmd.flag_empty) res_status <= ST_EMPTY;
    if (cmd.delay_empty) res_delay <= 48'(cfg_prop);
    if (cmd.delay_eval) res_delay <= delay_sat;
    if (cmd.walk_add_full) acc <= acc + 49'(full);
    if (cmd.walk_add_q) acc <= acc + 49'(div_q);
    if (cmd.walk_finish && op_kind == KIND_DELIVERED) begin
      acc <= acc + 49'({delivered, 16'h0000});
    end
    if (cmd.walk_next) walk_k <= walk_k + 1'b1;
    if (cmd.mul_lo) begin
      prod_lo  <= 50'(full) * 50'(num_w[17:0]);
      num_hi   <= num_w[35:18];
      frac_den <= den_w[35:0];
    end
    if (cmd.mul_hi) begin
      prod <= 68'(prod_lo) + (68'(50'(full) * 50'(num_hi)) << 18);
    end
    if (cmd.out_load) begin
      status          <= res_status;
      byte_amount_q16 <= acc[48] ? T48_MAX : acc[47:0];
      remaining_delay <= res_delay;
      dropped_total   <= drop_count;
    end
  end

endmodule

[rtl/dtlq_ctrl.sv]
// Controller state machine: sequences each item and owns the handshakes.
// Depends on dtlq_pkg.
module dtlq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dtlq_pkg::dp_stat_t stat,
  output dtlq_pkg::dp_cmd_t  cmd
);
  import dtlq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (stat.kind)
          KIND_PUSH:      state_next = stat.push_ok ? S_PUSH_DIV : S_DONE;
          KIND_POP:       state_next = stat.empty ? S_DONE : S_POP;
          KIND_INFLIGHT:  state_next = S_WALK_RD;
          KIND_DELIVERED: state_next = S_WALK_RD;
          KIND_DELAY:     state_next = stat.empty ? S_DONE : S_DELAY;
          default:        state_next = S_DONE;
        endcase
      end
      S_PUSH_DIV: if (stat.div_done) state_next = S_DONE;
      S_POP:      state_next = S_DONE;
      S_DELAY:    state_next = S_DONE;
      S_WALK_RD:  state_next = stat.walk_more ? S_WALK_EVAL : S_DONE;
      S_WALK_EVAL: begin
        case (stat.eval)
          EV_FRAC: state_next = S_MUL_HI;
          default: state_next = S_WALK_RD;
        endcase
      end
      S_MUL_HI:    state_next = S_DIV_START;
      S_DIV_START: state_next = S_FRAC_DIV;
      S_FRAC_DIV:  if (stat.div_done) state_next = S_WALK_RD;
      S_DONE:      if (!out_valid || !out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_HEAD;
    case (state)
      S_IDLE: cmd.latch_in = in_valid;
      S_DISPATCH: begin
        cmd.rd_en = 1'b1;
        case (stat.kind)
          KIND_PUSH: begin
            cmd.rd_sel         = RD_TAIL;
            cmd.drop           = !stat.push_ok;
            cmd.push_div_start = stat.push_ok;
          end
          KIND_POP: cmd.flag_empty = stat.empty;
          KIND_DELAY: begin
            cmd.rd_sel      = RD_TAIL;
            cmd.delay_empty = stat.empty;
          end
          default: ;
        endcase
      end
      S_PUSH_DIV: cmd.push_commit = stat.div_done;
      S_POP:      cmd.pop_commit = 1'b1;
      S_DELAY:    cmd.delay_eval = 1'b1;
      S_WALK_RD: begin
        cmd.rd_sel      = RD_WALK;
        cmd.rd_en       = stat.walk_more;
        cmd.walk_finish = !stat.walk_more;
      end
      S_WALK_EVAL: begin
        case (stat.eval)
          EV_FULL: begin
            cmd.walk_add_full = 1'b1;
            cmd.walk_next     = 1'b1;
          end
          EV_FRAC: cmd.mul_lo = 1'b1;
          default: cmd.walk_next = 1'b1;
        endcase
      end
      S_MUL_HI:    cmd.mul_hi = 1'b1;
      S_DIV_START: cmd.frac_div_start = 1'b1;
      S_FRAC_DIV: begin
        cmd.walk_add_q = stat.div_done;
        cmd.walk_next  = stat.div_done;
      end
      S_DONE:  cmd.out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

endmodule

[rtl/drop_tail_link_queue_timer.sv]
// Drop-tail link buffer with serialization delay timing.
// Input channel: in_valid/in_stall with kind, packet_bytes, now_ticks; an item
// is taken when in_valid is high and in_stall is low. Each item gives exactly
// one result on out_valid/out_stall: status, byte_amount_q16,
// remaining_delay, dropped_total.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 limit, 1 propagation
// delay, 2 rate) and cfg_data; cfg_ready is always high. Write only while idle.
// One item at a time. Drops, pops of an empty queue, delay queries of an empty
// queue and unknown kinds go from dispatch straight to the done state and the
// output register; other pops and delay queries pass one more state first.
// An admitted push waits on the shared 36-step divider. Byte queries walk the
// occupied slots one by one; a slot with a partial transfer is multiplied in
// two halves and then divided on the divider.
// A finished result sits in the output register while the receiver stalls;
// the next item is taken once that result has been loaded.
// Reset (rst, synchronous) empties the queue, clears the counters and
// restores the configuration defaults.
// Depends on dtlq_pkg, dtlq_ctrl, dtlq_dp, dtlq_div.
module drop_tail_link_queue_timer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         kind,
  input  logic [15:0]        packet_bytes,
  input  logic [47:0]        now_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [47:0]        byte_amount_q16,
  output logic signed [47:0] remaining_delay,
  output logic [31:0]        dropped_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dtlq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  dtlq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtlq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .packet_bytes    (packet_bytes),
    .now_ticks       (now_ticks),
    .status          (status),
    .byte_amount_q16 (byte_amount_q16),
    .remaining_delay (remaining_delay),
    .dropped_total   (dropped_total)
  );

endmodule

[rtl/dtlq_chk.sv]
// Port-level checker for the drop-tail link queue timer, bound to the top.
// Depends on dtlq_pkg and drop_tail_link_queue_timer_defines.svh.
`include "drop_tail_link_queue_timer_defines.svh"

module dtlq_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [47:0]        byte_amount_q16,
  input logic signed [47:0] remaining_delay,
  input logic [31:0]        dropped_total
);
  import dtlq_pkg::*;

  `DTLQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(byte_amount_q16) && $stable(dropped_total), "stalled result changed")
  `DTLQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")
  `DTLQ_ASSERT_SAME(a_drop_counted, out_valid && status == ST_DROP, dropped_total != 32'd0, "drop reported without count")
  `DTLQ_ASSERT_SAME(a_error_zero, out_valid && status != ST_OK, byte_amount_q16 == 48'd0 && remaining_delay == 48'sd0, "error result carries data")

endmodule

bind drop_tail_link_queue_timer dtlq_chk u_dtlq_chk (.*);

[sim/testbench.sv]
// Testbench for the drop-tail link queue timer: directed and random items,
// predicted in-line and checked field by field on the result channel.
// Depends on dtlq_pkg and drop_tail_link_queue_timer.
`timescale 1ns / 1ps

module testbench;
  import dtlq_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] bytes;
    logic [47:0] now;
  } link_item_t;

  typedef struct {
    logic [1:0]         status;
    logic [47:0]        amount;
    logic signed [47:0] delay;
    logic [31:0]        drops;
  } link_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [15:0] packet_bytes = '0;
  logic [47:0] now_ticks = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [47:0] byte_amount_q16;
  logic signed [47:0] remaining_delay;
  logic [31:0] dropped_total;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  drop_tail_link_queue_timer DUT (.*);

  initial forever #1 clk = ~clk;

  // link shadow state
  logic [15:0] q_size [QUEUE_DEPTH];
  logic [47:0] q_start [QUEUE_DEPTH];
  logic [47:0] q_end [QUEUE_DEPTH];
  int unsigned q_head, q_count;
  longint unsigned q_bytes, delivered, drop_cnt;
  longint unsigned lim_cfg = 65536, prop_cfg = 0, rate_cfg = 65536;

  link_item_t pending_items[$];
  link_result_t expected_results[$];
  int errors = 0;
  bit quiet_mode = 0;
  bit hold_off = 0;
  longint cycles = 0;

  function automatic longint unsigned sat48(longint unsigned v);
    return v > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : v;
  endfunction

  // floor(a*b/d), exact via 128-bit product
  function automatic longint unsigned scale_frac(longint unsigned a, longint unsigned b,
                                                 longint unsigned d);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p / 128'(d));
  endfunction

  function automatic link_result_t predict_link(link_item_t it);
    link_result_t r;
    longint unsigned rate, start, dur, full, amt, sz;
    longint signed d;
    int unsigned s;
    r.status = ST_OK; r.amount = '0; r.delay = '0;
    amt = 0;
    case (it.kind)
      KIND_PUSH: begin
        if (q_bytes + it.bytes < lim_cfg && q_count < QUEUE_DEPTH) begin
          rate = rate_cfg == 0 ? 1 : rate_cfg;
          start = sat48(it.now + prop_cfg);
          dur = ((64'(it.bytes) * 8) << 16) / rate;
          if (q_count > 0 && q_end[(q_head + q_count - 1) % QUEUE_DEPTH] > start)
            start = q_end[(q_head + q_count - 1) % QUEUE_DEPTH];
          s = (q_head + q_count) % QUEUE_DEPTH;
          q_size[s] = it.bytes; q_start[s] = start; q_end[s] = sat48(start + dur);
          q_count++; q_bytes += it.bytes;
        end else begin
          r.status = ST_DROP;
          if (drop_cnt < 64'hFFFF_FFFF) drop_cnt++;
        end
      end
      KIND_POP: begin
        if (q_count == 0) r.status = ST_EMPTY;
        else begin
          sz = q_size[q_head];
          delivered += sz;
          if (delivered > 64'hFFFF_FFFF) delivered = 64'hFFFF_FFFF;
          q_bytes = q_bytes >= sz ? q_bytes - sz : 0;
          q_head = (q_head + 1) % QUEUE_DEPTH; q_count--;
        end
      end
      KIND_INFLIGHT: begin
        for (int k = 0; k < q_count; k++) begin
          s = (q_head + k) % QUEUE_DEPTH;
          full = 64'(q_size[s]) << 16;
          if (it.now < q_start[s]) amt += full;
          else if (it.now < q_end[s])
            amt += scale_frac(full, q_end[s] - it.now, q_end[s] - q_start[s]);
        end
        r.amount = sat48(amt);
      end
      KIND_DELIVERED: begin
        for (int k = 0; k < q_count; k++) begin
          s = (q_head + k) % QUEUE_DEPTH;
          full = 64'(q_size[s]) << 16;
          if (it.now > q_end[s]) amt += full;
          else if (it.now > q_start[s])
            amt += scale_frac(full, it.now - q_start[s], q_end[s] - q_start[s]);
        end
        amt += delivered << 16;
        r.amount = sat48(amt);
        delivered = 0;
      end
      KIND_DELAY: begin
        if (q_count == 0) d = longint'(prop_cfg);
        else begin
          d = longint'(q_end[(q_head + q_count - 1) % QUEUE_DEPTH]) - longint'(it.now);
          if (d > 64'sh7FFF_FFFF_FFFF) d = 64'sh7FFF_FFFF_FFFF;
          if (d < -64'sh8000_0000_0000) d = -64'sh8000_0000_0000;
        end
        r.delay = d[47:0];
      end
      default: ;
    endcase
    r.drops = drop_cnt[31:0];
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, predict_link(pending_items.pop_front())};
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 0;
        end else if ((in_valid && !in_stall ? pending_items.size() : pending_items.size())
                     > 0 && !(in_valid && !in_stall && pending_items.size() == 0)) begin
          in_valid <= 1;
          kind <= pending_items[0].kind;
          packet_bytes <= pending_items[0].bytes;
          now_ticks <= pending_items[0].now;
          if (!quiet_mode && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 17);
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    link_result_t e;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected"); errors++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status exp %0d got %0d", e.status, status); errors++;
          end
          if (byte_amount_q16 !== e.amount) begin
            $error("byte_amount_q16 exp %0h got %0h", e.amount, byte_amount_q16); errors++;
          end
          if (remaining_delay !== e.delay) begin
            $error("remaining_delay exp %0d got %0d", e.delay, remaining_delay); errors++;
          end
          if (dropped_total !== e.drops) begin
            $error("dropped_total exp %0d got %0d", e.drops, dropped_total); errors++;
          end
        end
      end
      if (hold_off) out_stall <= 1;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1; out_stall <= 1;
      end else begin
        out_stall <= 0;
        if (!quiet_mode && $urandom_range(0, 15) == 0) recv_gap <= $urandom_range(1, 17);
      end
    end
  end

  // long hold-off on the result side, counted in its own process
  initial begin
    int n;
    wait (pending_items.size() > 100);
    @(posedge clk);
    hold_off <= 1;
    for (n = 0; n < 3000; n++) @(posedge clk);
    hold_off <= 0;
  end

  always @(posedge clk) begin
    if (cycles > 4_000_000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic link_item_t make_item(logic [2:0] k, logic [15:0] b, logic [47:0] t);
    link_item_t it;
    it.kind = k; it.bytes = b; it.now = t;
    return it;
  endfunction

  // append an item to the pending queue
  function automatic void queue_item(link_item_t it);
    pending_items = {pending_items, it};
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_LIMIT: lim_cfg = v & 32'hFF_FFFF;
      CFG_PROP: prop_cfg = v;
      default: rate_cfg = v;
    endcase
  endtask

  // random sequences: a random mix of pushes, pops, queries and other kinds, mostly with rising time
  task automatic random_phase(int n, longint unsigned t0);
    longint unsigned t;
    logic [2:0] k;
    logic [15:0] b;
    t = t0;
    repeat (n) begin
      t += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 3000);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: k = KIND_PUSH;
        4, 5: k = KIND_POP;
        6: k = KIND_INFLIGHT;
        7: k = KIND_DELIVERED;
        8: k = KIND_DELAY;
        default: k = 3'($urandom_range(0, 7));
      endcase
      b = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
      queue_item(make_item(k, b,
        $urandom_range(0, 19) == 0 ? {16'($urandom), 32'($urandom)} : 48'(t)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty pop, empty queries, extremes, unknown kinds
    queue_item(make_item(KIND_POP, 0, 0));
    queue_item(make_item(KIND_DELAY, 0, 0));
    queue_item(make_item(KIND_INFLIGHT, 0, 0));
    queue_item(make_item(KIND_PUSH, 0, 100));
    queue_item(make_item(KIND_INFLIGHT, 0, 100));
    queue_item(make_item(KIND_DELIVERED, 0, 101));
    queue_item(make_item(KIND_PUSH, 16'hFFFF, 200));
    queue_item(make_item(KIND_PUSH, 16'hFFFF, 200));
    queue_item(make_item(KIND_PUSH, 1000, 48'hFFFF_FFFF_FFF0));
    queue_item(make_item(KIND_INFLIGHT, 0, 300));
    queue_item(make_item(KIND_DELIVERED, 0, 4000));
    queue_item(make_item(KIND_DELAY, 0, 48'hFFFF_FFFF_FFFF));
    queue_item(make_item(KIND_DELAY, 0, 0));
    queue_item(make_item(3'd5, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
    queue_item(make_item(3'd7, 0, 0));
    queue_item(make_item(KIND_POP, 0, 0));
    queue_item(make_item(KIND_POP, 0, 0));
    queue_item(make_item(KIND_DELIVERED, 0, 0));
    random_phase(250, 1000);
    drain();
    write_reg(CFG_LIMIT, 32'hFF_FFFF);
    write_reg(CFG_PROP, 32'hFFFF_FFFF);
    write_reg(CFG_RATE, 32'hFFFF_FFFF);
    random_phase(150, 5000);
    drain();
    write_reg(CFG_LIMIT, 0);
    write_reg(CFG_RATE, 0);
    random_phase(30, 0);
    drain();
    write_reg(CFG_LIMIT, 20000);
    write_reg(CFG_PROP, 500);
    write_reg(CFG_RATE, 1);
    random_phase(200, 48'hFFFF_FFFF_0000);
    drain();
    write_reg(CFG_LIMIT, 300000);
    write_reg(CFG_PROP, 0);
    write_reg(CFG_RATE, 32'h0008_0000);
    quiet_mode = 1;
    random_phase(220, 77);
    drain();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
